// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the compressor design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SVZ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SVZ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// File: design/svz_pkg.sv
// ---------------------------------------------------------------------------
// Zero-skip compressor package
// Field widths, stream packing offsets, register indexes and shared types.
// ---------------------------------------------------------------------------
package svz_pkg;

	localparam int LANES_DEF       = 8;
	localparam int DATA_WIDTH_DEF  = 8;
	localparam int GROUP_WIDTH_DEF = 8;

	localparam int VEC_WIDTH      = 64;
	localparam int COUNT_WIDTH    = 4;
	localparam int VALUE_WIDTH    = 8;
	localparam int OFFSET_WIDTH   = 3;
	localparam int GROUP_IN_WIDTH = 8;
	localparam int WIN_LEN_WIDTH  = 4;
	localparam int WINDOW_MAX     = 8;

	localparam int IN_COUNT_LSB    = 64;
	localparam int IN_GROUP_LSB    = 68;
	localparam int IN_TDATA_WIDTH  = 80;
	localparam int OUT_OFFSET_LSB  = 8;
	localparam int OUT_GROUP_LSB   = 11;
	localparam int OUT_TDATA_WIDTH = 24;
	localparam int IN_TUSER_WIDTH  = 1;
	localparam int OUT_TUSER_WIDTH = 2;

	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH  = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COMPRESS = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET   = 1'b1;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0]  value;
		logic [OFFSET_WIDTH-1:0] offset;
		logic                    last;
	} step_t;

endpackage

// File: design/svz_lane.sv
// ---------------------------------------------------------------------------
// Compressor lane
// Extracts one element, tests it against zero and the element count.
// ---------------------------------------------------------------------------
module svz_lane #(
	parameter int LANE       = 0,
	parameter int DATA_WIDTH = svz_pkg::DATA_WIDTH_DEF
) (
	input  logic [svz_pkg::VEC_WIDTH-1:0]   vector_data,
	input  logic [svz_pkg::COUNT_WIDTH-1:0] element_count,
	input  logic                            compress,
	output logic [svz_pkg::VALUE_WIDTH-1:0] value,
	output logic                            keep
);

	localparam int SHIFT = LANE * DATA_WIDTH;
	localparam int VW    = svz_pkg::VALUE_WIDTH;

	logic [svz_pkg::VEC_WIDTH-1:0] shifted;
	logic [DATA_WIDTH-1:0]         elem;

	// Elements that lie past the top of the vector read as zero.
	assign shifted = vector_data >> SHIFT;
	assign elem    = shifted[DATA_WIDTH-1:0];
	assign value   = VW'(elem);
	assign keep    = (int'(element_count) > LANE) && (!compress || (|elem));

endmodule

// File: design/svz_select.sv
// ---------------------------------------------------------------------------
// Compressor merge stage
// Finds the lowest pending lane in the window and advances the mask.
// ---------------------------------------------------------------------------
module svz_select #(
	parameter int LANES = svz_pkg::LANES_DEF,
	localparam int BASE_W  = $clog2(LANES + 1),
	localparam int IDX_W   = $clog2(LANES),
	localparam int WIN_MAX = (LANES < svz_pkg::WINDOW_MAX) ? LANES : svz_pkg::WINDOW_MAX
) (
	input  logic [LANES-1:0]                  pending,
	input  logic [svz_pkg::WIN_LEN_WIDTH-1:0] win_len,
	input  logic [BASE_W-1:0]                 base,
	input  logic [svz_pkg::VALUE_WIDTH-1:0]   values [LANES],
	output svz_pkg::step_t                    step,
	output logic [LANES-1:0]                  pending_next,
	output logic [BASE_W-1:0]                 base_next
);

	localparam int OW = svz_pkg::OFFSET_WIDTH;

	logic [WIN_MAX-1:0]                win_mask;
	logic [WIN_MAX-1:0]                sel;
	logic [WIN_MAX-1:0]                onehot;
	logic [LANES-1:0]                  rest;
	logic                              hit;
	logic [OW-1:0]                     off;
	logic [svz_pkg::WIN_LEN_WIDTH-1:0] win_m1;
	logic [BASE_W:0]                   idx_sum;
	logic [IDX_W-1:0]                  idx;

	always_comb begin
		for (int i = 0; i < WIN_MAX; i++) begin
			win_mask[i] = (i < int'(win_len));
		end
	end

	assign sel    = pending[WIN_MAX-1:0] & win_mask;
	assign onehot = sel & (~sel + WIN_MAX'(1));
	assign win_m1 = win_len - svz_pkg::WIN_LEN_WIDTH'(1);

	always_comb begin
		hit = 1'b0;
		off = win_m1[OW-1:0];
		for (int i = WIN_MAX - 1; i >= 0; i--) begin
			if (sel[i]) begin
				hit = 1'b1;
				off = OW'(i);
			end
		end
	end

	assign rest    = pending & ~LANES'(onehot);
	assign idx_sum = {1'b0, base} + (BASE_W + 1)'(off);
	assign idx     = idx_sum[IDX_W-1:0];

	assign step.value   = hit ? values[idx] : '0;
	assign step.offset  = off;
	assign step.last    = (rest == '0);
	assign pending_next = pending >> ({1'b0, off} + (OW + 1)'(1));
	assign base_next    = BASE_W'(idx_sum + (BASE_W + 1)'(1));

endmodule

// File: design/sparse_vector_zero_skip_compressor.sv
// ---------------------------------------------------------------------------
// Sparse vector zero-skip compressor
// Turns each input vector into a run of (value, skip offset) results.
// ---------------------------------------------------------------------------
// Vectors arrive on the s_ stream and results leave on the m_ stream; an item
// moves when tvalid and tready are both high. On acceptance every lane tests
// its element at once and the kept lanes form a pending mask. The merge stage
// then emits one result per cycle: the lowest kept lane in the window, or a
// zero filler when the window is empty. m_tlast marks the final result of the
// vector. The first result is registered after the vector is captured. A vector
// gives between 1 and LANES results, as the single merge stage produces one
// result per cycle; the next vector is taken in the cycle of the previous one's
// last step. When the receiver stalls, the output register holds its result and
// the step sequencer waits. The configuration port writes compress_enable
// (index 0) and offset_width (index 1); the user writes them only while the
// block is idle, which the block does not enforce. Reset clears both registers,
// the output valid and the sequencer; no clearing pass is needed.
// ---------------------------------------------------------------------------
module sparse_vector_zero_skip_compressor #(
	parameter int LANES       = svz_pkg::LANES_DEF,
	parameter int DATA_WIDTH  = svz_pkg::DATA_WIDTH_DEF,
	parameter int GROUP_WIDTH = svz_pkg::GROUP_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [svz_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [svz_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// vector_data[63:0], element_count[67:64], group_tag[75:68], zero pad
	input  logic [svz_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,
	// vector_begin[0]
	input  logic [svz_pkg::IN_TUSER_WIDTH-1:0]  s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// value_out[7:0], skip_offset[10:8], group_out[18:11], zero pad
	output logic [svz_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
	// stream_last[0], first_of_vector[1]
	output logic [svz_pkg::OUT_TUSER_WIDTH-1:0] m_tuser,
	output logic                                m_tlast
);

`include "assert_macros.svh"

	localparam int BASE_W = $clog2(LANES + 1);
	localparam int VW     = svz_pkg::VALUE_WIDTH;
	localparam int OW     = svz_pkg::OFFSET_WIDTH;
	localparam int GIW    = svz_pkg::GROUP_IN_WIDTH;
	localparam int GW     = (GROUP_WIDTH < GIW) ? GROUP_WIDTH : GIW;
	localparam int WLW    = svz_pkg::WIN_LEN_WIDTH;

	logic                   compress_q;
	logic [1:0]             ow_q;
	logic                   busy_q;
	logic                   first_q;
	logic [LANES-1:0]       pending_q;
	logic [BASE_W-1:0]      base_q;
	logic [VW-1:0]          vals_q [LANES];
	logic                   vlast_q;
	logic                   begin_q;
	logic [GW-1:0]          group_q;

	logic                   out_valid_q;
	logic [VW-1:0]          out_value_q;
	logic [OW-1:0]          out_offset_q;
	logic                   out_last_q;
	logic                   out_stream_q;
	logic                   out_first_q;
	logic [GW-1:0]          out_group_q;

	logic [VW-1:0]          lane_val [LANES];
	logic [LANES-1:0]       lane_keep;
	logic [WLW-1:0]         win_pow;
	logic [WLW-1:0]         win_len;
	svz_pkg::step_t         step;
	logic [LANES-1:0]       pending_next;
	logic [BASE_W-1:0]      base_next;
	logic                   step_en;
	logic                   accept;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		svz_lane #(
			.LANE       (g),
			.DATA_WIDTH (DATA_WIDTH)
		) u_lane (
			.vector_data   (s_tdata[svz_pkg::VEC_WIDTH-1:0]),
			.element_count (s_tdata[svz_pkg::IN_COUNT_LSB +: svz_pkg::COUNT_WIDTH]),
			.compress      (compress_q),
			.value         (lane_val[g]),
			.keep          (lane_keep[g])
		);
	end

	assign win_pow = WLW'(1) << ow_q;
	assign win_len = (int'(win_pow) > LANES) ? WLW'(LANES) : win_pow;

	svz_select #(
		.LANES (LANES)
	) u_select (
		.pending      (pending_q),
		.win_len      (win_len),
		.base         (base_q),
		.values       (vals_q),
		.step         (step),
		.pending_next (pending_next),
		.base_next    (base_next)
	);

	assign step_en  = busy_q && (!out_valid_q || m_tready);
	assign s_tready = !busy_q || (step_en && step.last);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compress_q <= 1'b0;
			ow_q       <= 2'd0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				svz_pkg::CFG_COMPRESS: compress_q <= cfg_wdata[0];
				svz_pkg::CFG_OFFSET:   ow_q       <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			first_q   <= 1'b0;
			pending_q <= '0;
			base_q    <= '0;
		end else if (accept) begin
			busy_q    <= 1'b1;
			first_q   <= 1'b1;
			pending_q <= lane_keep;
			base_q    <= '0;
		end else if (step_en) begin
			first_q   <= 1'b0;
			pending_q <= pending_next;
			base_q    <= base_next;
			if (step.last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < LANES; i++) begin
				vals_q[i] <= lane_val[i];
			end
			vlast_q <= s_tlast;
			begin_q <= s_tuser[0];
			group_q <= s_tdata[svz_pkg::IN_GROUP_LSB +: GW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_value_q  <= step.value;
			out_offset_q <= step.offset;
			out_last_q   <= step.last;
			out_stream_q <= vlast_q && step.last;
			out_first_q  <= begin_q && first_q;
			out_group_q  <= group_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_first_q, out_stream_q};
	assign m_tdata  = {
		(svz_pkg::OUT_TDATA_WIDTH - svz_pkg::OUT_GROUP_LSB - GIW)'(0),
		GIW'(out_group_q),
		out_offset_q,
		out_value_q
	};

	`SVZ_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, busy_q && first_q)
	`SVZ_ASSERT_NEXT(a_last_out, step_en && step.last, m_tvalid && m_tlast)
	`SVZ_ASSERT_IMPL(a_stream_is_run_last, m_tvalid && m_tuser[0], m_tlast)
	`SVZ_ASSERT_NEXT(a_stall_hold, busy_q && !step_en, $stable(pending_q) && $stable(base_q))

endmodule
